@@ sv/rotor_position_controller_macros.svh @@
// Assertion macros of the rotor position controller, used by rpc_step.
`ifndef ROTOR_POSITION_CONTROLLER_MACROS_SVH
`define ROTOR_POSITION_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define RPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define RPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rpc_pkg.sv @@
// Types and constants of the rotor position controller.
package rpc_pkg;

  // Command codes
  localparam logic [2:0] CMD_GOTO      = 3'd0;
  localparam logic [2:0] CMD_REL_CW    = 3'd1;
  localparam logic [2:0] CMD_REL_CCW   = 3'd2;
  localparam logic [2:0] CMD_STOP      = 3'd3;
  localparam logic [2:0] CMD_CALIBRATE = 3'd4;
  localparam logic [2:0] CMD_PULSE     = 3'd5;
  localparam logic [2:0] CMD_TICK      = 3'd6;

  // Status codes
  localparam logic [3:0] ST_NONE       = 4'd0;
  localparam logic [3:0] ST_STARTED    = 4'd1;
  localparam logic [3:0] ST_TOO_SMALL  = 4'd2;
  localparam logic [3:0] ST_STOPPED    = 4'd3;
  localparam logic [3:0] ST_CALIBRATED = 4'd4;
  localparam logic [3:0] ST_COUNTED    = 4'd5;
  localparam logic [3:0] ST_REACHED    = 4'd6;
  localparam logic [3:0] ST_TIMEOUT    = 4'd7;
  localparam logic [3:0] ST_IGNORED    = 4'd8;

  // Direction codes; bit 0 also drives the cw relay, bit 1 the ccw relay
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_CW   = 2'b01;
  localparam logic [1:0] DIR_CCW  = 2'b10;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POSITION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 3'd3;

  // Reset values of the configuration registers
  localparam logic signed [15:0] RST_MIN_POSITION  = -16'sd90;
  localparam logic signed [15:0] RST_MAX_POSITION  = 16'sd450;
  localparam logic [7:0]         RST_MIN_STEP      = 8'd3;
  localparam logic [7:0]         RST_TIMEOUT_LIMIT = 8'd4;

  localparam logic [7:0] IDLE_MAX = 8'hFF;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] angle;
    logic               pulse_level;
  } command_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [15:0] position;
    logic               rotating;
    logic               relay_cw;
    logic               relay_ccw;
  } result_t;

  typedef struct packed {
    logic signed [15:0] min_position;
    logic signed [15:0] max_position;
    logic [7:0]         min_step;
    logic [7:0]         timeout_limit;
  } cfg_t;

endpackage

@@ sv/rpc_cfg.sv @@
// Configuration register file of the rotor position controller.
module rpc_cfg
  import rpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [15:0]          wr_data,
  output cfg_t                 cfg
);

  // One register per index; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_position  <= RST_MIN_POSITION;
      cfg.max_position  <= RST_MAX_POSITION;
      cfg.min_step      <= RST_MIN_STEP;
      cfg.timeout_limit <= RST_TIMEOUT_LIMIT;
    end else if (wr_en) begin
      case (wr_index)
        REG_MIN_POSITION:  cfg.min_position  <= $signed(wr_data);
        REG_MAX_POSITION:  cfg.max_position  <= $signed(wr_data);
        REG_MIN_STEP:      cfg.min_step      <= wr_data[7:0];
        REG_TIMEOUT_LIMIT: cfg.timeout_limit <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/rpc_step.sv @@
// Rotor state registers and the per-command update logic.
module rpc_step
  import rpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     go,
  input  command_t item,
  input  cfg_t     cfg,
  output result_t  res
);

  `include "rotor_position_controller_macros.svh"

  logic signed [15:0] position, position_next;
  logic signed [15:0] target, target_next;
  logic [1:0]         direction, direction_next;
  logic               active, active_next;
  logic [7:0]         idle_ticks, idle_ticks_next;
  logic [1:0]         relay, relay_next;
  logic [3:0]         status;

  logic signed [17:0] pos_x, ang_x, step_x, win_lo, win_hi;
  logic signed [16:0] ang_r, step_r;
  logic signed [15:0] pos_inc, pos_dec;
  logic [7:0]         idle_inc;

  // Widened operands for the goto window and relative-step compares
  assign pos_x   = {{2{position[15]}}, position};
  assign ang_x   = {{2{item.angle[15]}}, item.angle};
  assign step_x  = $signed({10'd0, cfg.min_step});
  assign win_lo  = pos_x - step_x;
  assign win_hi  = pos_x + step_x;
  assign ang_r   = {item.angle[15], item.angle};
  assign step_r  = $signed({9'd0, cfg.min_step});
  assign pos_inc = position + 16'sd1;
  assign pos_dec = position - 16'sd1;
  assign idle_inc = (idle_ticks == IDLE_MAX) ? idle_ticks : idle_ticks + 8'd1;

  // Next state and status for the command in the input register
  always_comb begin
    position_next   = position;
    target_next     = target;
    direction_next  = direction;
    active_next     = active;
    idle_ticks_next = idle_ticks;
    relay_next      = relay;
    status          = ST_NONE;
    case (item.cmd)
      CMD_GOTO: begin
        if (ang_x > win_lo && ang_x < win_hi) begin
          status = ST_TOO_SMALL;
        end else begin
          status = ST_STARTED;
          if (item.angle != position) begin
            target_next     = item.angle;
            active_next     = 1'b1;
            idle_ticks_next = '0;
            direction_next  = (item.angle > position) ? DIR_CW : DIR_CCW;
            relay_next      = (item.angle > position) ? DIR_CW : DIR_CCW;
          end
        end
      end
      CMD_REL_CW, CMD_REL_CCW: begin
        if (ang_r > step_r) begin
          status          = ST_STARTED;
          active_next     = 1'b1;
          idle_ticks_next = '0;
          if (item.cmd == CMD_REL_CW) begin
            target_next    = position + item.angle;
            direction_next = DIR_CW;
            relay_next     = DIR_CW;
          end else begin
            target_next    = position - item.angle;
            direction_next = DIR_CCW;
            relay_next     = DIR_CCW;
          end
        end else begin
          status = ST_TOO_SMALL;
        end
      end
      CMD_STOP: begin
        status      = ST_STOPPED;
        active_next = 1'b0;
        relay_next  = DIR_NONE;
      end
      CMD_CALIBRATE: begin
        status        = ST_CALIBRATED;
        position_next = item.angle;
      end
      CMD_PULSE: begin
        if (direction == DIR_CW && item.pulse_level) begin
          idle_ticks_next = '0;
          position_next   = pos_inc;
          status          = ST_COUNTED;
          if (active && (pos_inc > cfg.max_position || pos_inc >= target)) begin
            status      = ST_REACHED;
            active_next = 1'b0;
            relay_next  = DIR_NONE;
          end
        end else if (direction == DIR_CCW && !item.pulse_level) begin
          idle_ticks_next = '0;
          position_next   = pos_dec;
          status          = ST_COUNTED;
          if (active && (pos_dec < cfg.min_position || pos_dec <= target)) begin
            status      = ST_REACHED;
            active_next = 1'b0;
            relay_next  = DIR_NONE;
          end
        end else begin
          status = ST_IGNORED;
        end
      end
      CMD_TICK: begin
        if (active) begin
          idle_ticks_next = idle_inc;
          if (idle_inc > cfg.timeout_limit) begin
            status      = ST_TIMEOUT;
            active_next = 1'b0;
            relay_next  = DIR_NONE;
          end
        end
      end
      default: ;
    endcase
  end

  // State update, one command per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      target     <= '0;
      direction  <= DIR_NONE;
      active     <= 1'b0;
      idle_ticks <= '0;
      relay      <= DIR_NONE;
    end else if (go) begin
      position   <= position_next;
      target     <= target_next;
      direction  <= direction_next;
      active     <= active_next;
      idle_ticks <= idle_ticks_next;
      relay      <= relay_next;
    end
  end

  // Result beat as seen after this command
  assign res.status    = status;
  assign res.position  = position_next;
  assign res.rotating  = active_next;
  assign res.relay_cw  = relay_next[0];
  assign res.relay_ccw = relay_next[1];

  `RPC_ASSERT_NOW(a_relay_exclusive, clk, rst, 1'b1, $onehot0(relay), "both relays driven")
  `RPC_ASSERT_NOW(a_relay_tracks_active, clk, rst, 1'b1, active == (relay != DIR_NONE), "relay state disagrees with rotation flag")
  `RPC_ASSERT_NEXT(a_position_held, clk, rst, !go, $stable(position), "position moved without a command")

endmodule

@@ sv/rotor_position_controller.sv @@
// Top level of the rotor position controller: beat registers around the update logic.
// Accepts one command per clock unless the result side stalls; each command
// gives exactly one result beat, through the input register and then the result
// register, and the command and result sides run without bubbles as long as
// the result side takes a beat every cycle. All rotor state is updated by the
// logic between the two registers, so throughput is one command per clock unless
// the result side stalls. Configuration writes are taken at any time through their
// own channel and must only be issued while no command is in flight.
module rotor_position_controller
  import rpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 command_valid,
  output logic                 command_ready,
  input  command_t             command,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic     item_valid;
  command_t item;
  logic     go;
  cfg_t     cfg;
  result_t  res;

  // Command leaves the input register when the result register is free
  assign go            = item_valid && (!result_valid || result_ready);
  assign command_ready = !item_valid || go;
  assign cfg_ready     = 1'b1;

  rpc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rpc_step u_step (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (command_ready) begin
      item_valid <= command_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (command_ready && command_valid) begin
      item <= command;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result <= res;
    end
  end

endmodule

@@ tb/rotor_position_controller_checker.sv @@
// Checker for the rotor position controller: predicts every result beat and compares it.
module rotor_position_controller_checker
  import rpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 command_valid,
  input  logic                 command_ready,
  input  command_t             command,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  result_t              result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   fail_count,
  output int                   expected_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // Predicted configuration
  logic signed [15:0] lim_lo, lim_hi;
  logic [7:0]         step_min, tick_limit;

  // Predicted rotor state
  logic [15:0] pos_q, target_q;
  logic [1:0]  dir_q, relays_q;
  logic        moving_q;
  logic [7:0]  quiet_ticks;

  result_t due_results[$];

  function automatic void stop_motor();
    moving_q = 1'b0;
    relays_q = DIR_NONE;
  endfunction

  // Direction code doubles as the relay drive pattern
  function automatic void start_motor(input logic [1:0] dir);
    moving_q    = 1'b1;
    quiet_ticks = '0;
    dir_q       = dir;
    relays_q    = dir;
  endfunction

  function automatic result_t predict_rotor(input command_t c);
    result_t r;
    int      here, ang, step;
    r    = '0;
    here = $signed(pos_q);
    ang  = c.angle;
    step = step_min;
    r.status = ST_NONE;
    case (c.cmd)
      CMD_GOTO: begin
        // refused when strictly inside the window around the current position
        if (ang > here - step && ang < here + step) begin
          r.status = ST_TOO_SMALL;
        end else begin
          if (ang > here) begin
            target_q = c.angle;
            start_motor(DIR_CW);
          end else if (ang < here) begin
            target_q = c.angle;
            start_motor(DIR_CCW);
          end
          r.status = ST_STARTED;
        end
      end
      CMD_REL_CW, CMD_REL_CCW: begin
        if (ang > step) begin
          if (c.cmd == CMD_REL_CW) begin
            target_q = pos_q + c.angle;
            start_motor(DIR_CW);
          end else begin
            target_q = pos_q - c.angle;
            start_motor(DIR_CCW);
          end
          r.status = ST_STARTED;
        end else begin
          r.status = ST_TOO_SMALL;
        end
      end
      CMD_STOP: begin
        stop_motor();
        r.status = ST_STOPPED;
      end
      CMD_CALIBRATE: begin
        pos_q    = c.angle;
        r.status = ST_CALIBRATED;
      end
      CMD_PULSE: begin
        // edges count only when the level matches the last direction
        if (dir_q == DIR_CW && c.pulse_level) begin
          quiet_ticks = '0;
          pos_q       = pos_q + 16'd1;
          r.status    = ST_COUNTED;
          if (moving_q && ($signed(pos_q) > lim_hi || $signed(pos_q) >= $signed(target_q))) begin
            stop_motor();
            r.status = ST_REACHED;
          end
        end else if (dir_q == DIR_CCW && !c.pulse_level) begin
          quiet_ticks = '0;
          pos_q       = pos_q - 16'd1;
          r.status    = ST_COUNTED;
          if (moving_q && ($signed(pos_q) < lim_lo || $signed(pos_q) <= $signed(target_q))) begin
            stop_motor();
            r.status = ST_REACHED;
          end
        end else begin
          r.status = ST_IGNORED;
        end
      end
      CMD_TICK: begin
        // watchdog: saturating count of ticks without a pulse
        if (moving_q) begin
          if (quiet_ticks != IDLE_MAX) quiet_ticks++;
          if (quiet_ticks > tick_limit) begin
            stop_motor();
            r.status = ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
    r.position  = pos_q;
    r.rotating  = moving_q;
    r.relay_cw  = relays_q[0];
    r.relay_ccw = relays_q[1];
    return r;
  endfunction

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", what);
  endtask

  // Watch the three channels at each rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      lim_lo      = RST_MIN_POSITION;
      lim_hi      = RST_MAX_POSITION;
      step_min    = RST_MIN_STEP;
      tick_limit  = RST_TIMEOUT_LIMIT;
      pos_q       = '0;
      target_q    = '0;
      dir_q       = DIR_NONE;
      relays_q    = DIR_NONE;
      moving_q    = 1'b0;
      quiet_ticks = '0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_POSITION:  lim_lo     = cfg_data;
          REG_MAX_POSITION:  lim_hi     = cfg_data;
          REG_MIN_STEP:      step_min   = cfg_data[7:0];
          REG_TIMEOUT_LIMIT: tick_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          report($sformatf("unexpected result beat: status %0d position %0d",
                           result.status, result.position));
        end else begin
          want = due_results.pop_front();
          if (result.status !== want.status || result.position !== want.position ||
              result.rotating !== want.rotating || result.relay_cw !== want.relay_cw ||
              result.relay_ccw !== want.relay_ccw) begin
            report($sformatf({"result mismatch (expected/actual): status %0d/%0d ",
                              "position %0d/%0d rotating %0b/%0b cw %0b/%0b ccw %0b/%0b"},
                             want.status, result.status, want.position, result.position,
                             want.rotating, result.rotating, want.relay_cw, result.relay_cw,
                             want.relay_ccw, result.relay_ccw));
          end
        end
      end
      if (command_valid && command_ready) due_results.push_back(predict_rotor(command));
    end
    expected_pending = due_results.size();
  end

endmodule

@@ tb/rotor_position_controller_tb.sv @@
// Testbench top for the rotor position controller: stimulus, handshake pacing and verdict.
module rotor_position_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 140;

  logic                 clk, rst;
  logic                 command_valid, command_ready;
  command_t             command;
  logic                 result_valid, result_ready;
  result_t              result;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  int                   fail_count, expected_pending;

  int send_idle_pct, recv_stall_pct, phase_items, cycles;
  int cur_min, cur_max, cur_step, cur_timeout;

  rotor_position_controller uut (
    .clk(clk), .rst(rst),
    .command_valid(command_valid), .command_ready(command_ready), .command(command),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rotor_position_controller_checker watch (
    .clk(clk), .rst(rst),
    .command_valid(command_valid), .command_ready(command_ready), .command(command),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .expected_pending(expected_pending)
  );

  initial clk = 1'b0;
  always #5ns clk = ~clk;

  // Run-length guard
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side stalls at random
  always @(negedge clk) begin
    result_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // One command beat; valid held until accepted
  task automatic send(input logic [2:0] op, input logic [15:0] ang, input logic lvl);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    command.cmd         = op;
    command.angle       = ang;
    command.pulse_level = lvl;
    command_valid       = 1'b1;
    do @(posedge clk); while (!command_ready);
    @(negedge clk);
    command_valid = 1'b0;
    phase_items++;
  endtask

  task automatic drain();
    while (expected_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // All four registers, written only once the pipeline is empty
  task automatic set_config(input int lo, input int hi, input int st, input int tmo);
    drain();
    repeat (3) @(negedge clk);
    write_reg(REG_MIN_POSITION, 16'(lo));
    write_reg(REG_MAX_POSITION, 16'(hi));
    write_reg(REG_MIN_STEP, {8'($urandom), 8'(st)});
    write_reg(REG_TIMEOUT_LIMIT, {8'($urandom), 8'(tmo)});
    cur_min     = int'($signed(16'(lo)));
    cur_max     = int'($signed(16'(hi)));
    cur_step    = st & 255;
    cur_timeout = tmo & 255;
  endtask

  // Calibrate near an interesting point, start a move, then feed edges and ticks
  task automatic move_sequence();
    int   d, base, npulse, t, burst;
    logic cw;
    cw = 1'($urandom);
    d  = cur_step + int'($urandom_range(12)) - 2;
    if (d < 0) d = 0;
    if ($urandom_range(19) == 0) d = $urandom_range(32767);
    case ($urandom_range(5))
      0: base = cur_max - int'($urandom_range(6));
      1: base = cur_min + int'($urandom_range(6));
      2: base = 32767 - int'($urandom_range(6));
      3: base = -32768 + int'($urandom_range(6));
      default: base = int'($urandom_range(400)) - 200;
    endcase
    if ($urandom_range(7) != 0) send(CMD_CALIBRATE, 16'(base), 1'($urandom));
    if ($urandom_range(1)) send(CMD_GOTO, 16'(cw ? base + d : base - d), 1'($urandom));
    else send(cw ? CMD_REL_CW : CMD_REL_CCW, 16'(d), 1'($urandom));
    npulse = d + int'($urandom_range(3));
    if (npulse > 30) npulse = 30 + int'($urandom_range(10));
    repeat (npulse) begin
      t = $urandom_range(99);
      if (t < 8) begin
        burst = (cur_timeout + 2 > 8) ? 8 : cur_timeout + 2;
        repeat ($urandom_range(burst)) send(CMD_TICK, 16'($urandom), 1'($urandom));
      end else if (t < 13) begin
        send(CMD_PULSE, 16'($urandom), !cw);
      end else if (t < 15) begin
        send(CMD_STOP, 16'($urandom), 1'($urandom));
      end else begin
        send(CMD_PULSE, 16'($urandom), cw);
      end
    end
    if ($urandom_range(3) == 0) send(CMD_STOP, 16'($urandom), 1'($urandom));
  endtask

  // Mostly well-formed moves, some fully random beats
  task automatic run_random(input int items);
    phase_items = 0;
    while (phase_items < items) begin
      if ($urandom_range(99) < 15) send(3'($urandom), 16'($urandom), 1'($urandom));
      else move_sequence();
    end
  endtask

  initial begin
    int k;
    rst            = 1'b1;
    command_valid  = 1'b0;
    command        = '0;
    result_ready   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_min        = int'(RST_MIN_POSITION);
    cur_max        = int'(RST_MAX_POSITION);
    cur_step       = RST_MIN_STEP;
    cur_timeout    = RST_TIMEOUT_LIMIT;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: default limits, step 3, timeout 4
    send(CMD_TICK, 16'h0000, 1'b0);           // idle tick
    send(CMD_PULSE, 16'h0000, 1'b1);          // no direction yet
    send(3'h7, 16'h7fff, 1'b1);               // undefined command
    send(CMD_GOTO, 16'sd2, 1'b0);             // inside the step window
    send(CMD_GOTO, 16'sd3, 1'b0);             // just outside: start cw
    send(CMD_PULSE, 16'h0000, 1'b0);          // wrong level
    repeat (3) send(CMD_PULSE, 16'hffff, 1'b1); // count up to target
    send(CMD_PULSE, 16'h0000, 1'b1);          // coasting edge still counts
    send(CMD_REL_CW, 16'h8000, 1'b0);         // negative relative move
    send(CMD_REL_CW, 16'sd4, 1'b0);
    repeat (5) send(CMD_TICK, 16'h0000, 1'b0); // watchdog trips on the fifth
    send(CMD_CALIBRATE, 16'h7fff, 1'b0);
    send(CMD_REL_CW, 16'sd10, 1'b0);          // target wraps past the top
    send(CMD_PULSE, 16'h0000, 1'b1);          // position wraps
    send(CMD_STOP, 16'h0000, 1'b0);
    send(CMD_CALIBRATE, 16'sd450, 1'b0);
    send(CMD_GOTO, 16'sd460, 1'b0);
    send(CMD_PULSE, 16'h0000, 1'b1);          // passes upper limit
    send(CMD_CALIBRATE, -16'sd90, 1'b0);
    send(CMD_REL_CCW, 16'sh7fff, 1'b0);
    send(CMD_PULSE, 16'h0000, 1'b0);          // passes lower limit
    run_random(PHASE_ITEMS);

    // Widest limits, no step minimum, watchdog never fires; sender idles
    set_config(-32768, 32767, 0, 255);
    for (k = 1; k <= 4; k++) begin
      write_reg(CFG_IDX_W'(int'(REG_TIMEOUT_LIMIT) + k), 16'($urandom));
    end
    send_idle_pct = 65;
    run_random(PHASE_ITEMS);

    // Tight limits, largest step, zero timeout; receiver stalls
    set_config(-20, 20, 255, 0);
    send_idle_pct  = 0;
    recv_stall_pct = 65;
    run_random(PHASE_ITEMS);

    // Random settings, both sides idle, with a full pause halfway
    set_config($urandom_range(65535), $urandom_range(65535), $urandom_range(20),
               $urandom_range(10));
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_random(PHASE_ITEMS / 2);
    drain();
    run_random(PHASE_ITEMS / 2);

    // Inverted extreme limits, step and timeout of one
    set_config(32767, -32768, 1, 1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/rpc_pkg.sv
sv/rpc_cfg.sv
sv/rpc_step.sv
sv/rotor_position_controller.sv
tb/rotor_position_controller_checker.sv
tb/rotor_position_controller_tb.sv
